// ----- design/lkr_pkg.sv -----
// Shared types and constants of the LRU-K frame replacer.
package lkr_pkg;

    localparam int FRAME_W = 6;
    localparam int COUNT_W = 5;
    localparam int TEV_W   = 7;
    localparam int K_W     = 5;

    localparam logic [K_W-1:0]     K_MIN     = 5'd2;
    localparam logic [K_W-1:0]     K_MAX     = 5'd16;
    localparam logic [K_W-1:0]     K_RESET   = 5'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    typedef enum logic [1:0] {
        REQ_ACCESS = 2'd0,
        REQ_SET    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_EVICT  = 2'd3
    } t_req;

    // One entry of the per-frame table; a count of zero means untracked.
    typedef struct packed {
        logic               in_cache;
        logic               mark;
        logic [COUNT_W-1:0] count;
    } t_ftab_entry;

    localparam int FTAB_W = $bits(t_ftab_entry);

endpackage

// ----- design/lkr_ram.sv -----
// Simple dual-port memory: one write port, one read port with registered data.
module lkr_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 6
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/lkr_ctrl.sv -----
// Sequencer of the replacer: frame table lookups, list scans, compaction and pushes.
module lkr_ctrl
    import lkr_pkg::*;
#(
    parameter int FRAME_SLOTS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [K_W-1:0]                    i_k,
    // request side
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  t_req                              i_req,
    input  logic [FRAME_W-1:0]                i_frame,
    input  logic                              i_flag,
    // result side
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [FRAME_W-1:0]                o_victim,
    output logic [TEV_W-1:0]                  o_count,
    // frame table
    output logic                              o_ft_we,
    output logic [$clog2(FRAME_SLOTS)-1:0]    o_ft_waddr,
    output t_ftab_entry                       o_ft_wdata,
    output logic [$clog2(FRAME_SLOTS)-1:0]    o_ft_raddr,
    input  t_ftab_entry                       i_ft_rdata,
    // history and cache order lists share addresses and write data
    output logic [$clog2(FRAME_SLOTS)-1:0]    o_ls_raddr,
    output logic [$clog2(FRAME_SLOTS)-1:0]    o_ls_waddr,
    output logic [FRAME_W-1:0]                o_ls_wdata,
    output logic                              o_hl_we,
    output logic                              o_cl_we,
    input  logic [FRAME_W-1:0]                i_hl_rdata,
    input  logic [FRAME_W-1:0]                i_cl_rdata
);

    localparam int IW = $clog2(FRAME_SLOTS);
    localparam int LW = $clog2(FRAME_SLOTS + 1);
    localparam int SW = (LW + 1 > TEV_W) ? LW + 1 : TEV_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_COMPACT,
        S_PUSH,
        S_DONE
    } t_state;

    function automatic logic [IW-1:0] f2i(input logic [FRAME_W-1:0] f);
        logic [IW+FRAME_W-1:0] w;
        w = {{IW{1'b0}}, f};
        return w[IW-1:0];
    endfunction

    t_state             r_state, n_state;
    logic [LW-1:0]      r_idx, n_idx;
    t_req               r_req, n_req;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic               r_flag, n_flag;
    logic               r_sel, n_sel;
    logic               r_push, n_push;
    logic               r_p1, n_p1;
    logic               r_p2, n_p2;
    logic               r_hit, n_hit;
    logic [IW-1:0]      r_pa, n_pa;
    logic [FRAME_W-1:0] r_c2, n_c2;
    logic [LW-1:0]      r_hlen, n_hlen;
    logic [LW-1:0]      r_clen, n_clen;
    logic [TEV_W-1:0]   r_tev, n_tev;
    logic               r_found, n_found;
    logic [FRAME_W-1:0] r_victim, n_victim;
    logic               r_out_valid, n_out_valid;
    logic               r_out_found, n_out_found;
    logic [FRAME_W-1:0] r_out_victim, n_out_victim;
    logic [TEV_W-1:0]   r_out_count, n_out_count;

    logic [LW-1:0]      cur_len;
    logic [FRAME_W-1:0] ls_rdata;
    logic               issue;
    logic               in_range;
    logic [COUNT_W-1:0] c_sat;

    assign cur_len  = r_sel ? r_clen : r_hlen;
    assign ls_rdata = r_sel ? i_cl_rdata : i_hl_rdata;
    assign issue    = (r_idx < cur_len);
    assign in_range = ({{IW{1'b0}}, i_frame} < (IW + FRAME_W)'(FRAME_SLOTS));
    assign c_sat    = (i_ft_rdata.count == COUNT_MAX) ? COUNT_MAX
                                                      : i_ft_rdata.count + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_req        = r_req;
        n_frame      = r_frame;
        n_flag       = r_flag;
        n_sel        = r_sel;
        n_push       = r_push;
        n_p1         = r_p1;
        n_p2         = r_p2;
        n_hit        = r_hit;
        n_pa         = r_pa;
        n_c2         = r_c2;
        n_hlen       = r_hlen;
        n_clen       = r_clen;
        n_tev        = r_tev;
        n_found      = r_found;
        n_victim     = r_victim;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_found  = r_out_found;
        n_out_victim = r_out_victim;
        n_out_count  = r_out_count;

        o_in_ready = 1'b0;
        o_ft_we    = 1'b0;
        o_ft_waddr = f2i(r_frame);
        o_ft_wdata = '0;
        o_ft_raddr = f2i(i_frame);
        o_ls_raddr = r_idx[IW-1:0];
        o_ls_waddr = r_pa - IW'(1);
        o_ls_wdata = ls_rdata;
        o_hl_we    = 1'b0;
        o_cl_we    = 1'b0;

        case (r_state)
            S_CLEAR: begin
                o_ft_we    = 1'b1;
                o_ft_waddr = r_idx[IW-1:0];
                if (r_idx == LW'(FRAME_SLOTS - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req    = i_req;
                    n_frame  = i_frame;
                    n_flag   = i_flag;
                    n_found  = 1'b0;
                    n_victim = '0;
                    n_push   = 1'b0;
                    n_idx    = '0;
                    n_p1     = 1'b0;
                    n_p2     = 1'b0;
                    n_hit    = 1'b0;
                    if (i_req == REQ_EVICT) begin
                        n_sel   = 1'b0;
                        n_state = S_SCAN;
                    end else if (in_range) begin
                        n_state = S_LOOKUP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LOOKUP: begin
                n_state = S_DONE;
                case (r_req)
                    REQ_ACCESS: begin
                        o_ft_we = 1'b1;
                        if (i_ft_rdata.count == '0) begin
                            o_ft_wdata = '{in_cache: 1'b0, mark: 1'b1, count: COUNT_W'(1)};
                            n_tev      = r_tev + 1'b1;
                            o_ls_waddr = r_hlen[IW-1:0];
                            o_ls_wdata = r_frame;
                            o_hl_we    = 1'b1;
                            n_hlen     = r_hlen + 1'b1;
                        end else if (!i_ft_rdata.in_cache) begin
                            if (c_sat >= i_k) begin
                                o_ft_wdata = '{in_cache: 1'b1, mark: i_ft_rdata.mark,
                                               count: c_sat};
                                n_sel      = 1'b0;
                                n_push     = 1'b1;
                                n_state    = S_COMPACT;
                            end else begin
                                o_ft_wdata = '{in_cache: 1'b0, mark: i_ft_rdata.mark,
                                               count: c_sat};
                            end
                        end else begin
                            o_ft_wdata = i_ft_rdata;
                            n_sel      = 1'b1;
                            n_push     = 1'b1;
                            n_state    = S_COMPACT;
                        end
                    end
                    REQ_SET: begin
                        if (i_ft_rdata.count != '0) begin
                            o_ft_we    = 1'b1;
                            o_ft_wdata = '{in_cache: i_ft_rdata.in_cache, mark: r_flag,
                                           count: i_ft_rdata.count};
                            if (!r_flag && i_ft_rdata.mark && r_tev != '0) begin
                                n_tev = r_tev - 1'b1;
                            end else if (r_flag && !i_ft_rdata.mark) begin
                                n_tev = r_tev + 1'b1;
                            end
                        end
                    end
                    REQ_REMOVE: begin
                        if (i_ft_rdata.count != '0) begin
                            o_ft_we = 1'b1;
                            if (i_ft_rdata.mark && r_tev != '0) begin
                                n_tev = r_tev - 1'b1;
                            end
                            n_sel   = i_ft_rdata.in_cache;
                            n_state = S_COMPACT;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                // Stage one reads the list, stage two the frame table entry it names.
                o_ft_raddr = f2i(ls_rdata);
                n_p1       = issue;
                n_p2       = r_p1;
                n_c2       = ls_rdata;
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_p2 && i_ft_rdata.mark) begin
                    n_found    = 1'b1;
                    n_victim   = r_c2;
                    n_frame    = r_c2;
                    o_ft_we    = 1'b1;
                    o_ft_waddr = f2i(r_c2);
                    if (r_tev != '0) begin
                        n_tev = r_tev - 1'b1;
                    end
                    n_idx   = '0;
                    n_p1    = 1'b0;
                    n_p2    = 1'b0;
                    n_hit   = 1'b0;
                    n_state = S_COMPACT;
                end else if (!issue && !r_p1 && !r_p2) begin
                    if (!r_sel) begin
                        n_sel = 1'b1;
                        n_idx = '0;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_COMPACT: begin
                // Read each entry once; entries after the match move down by one.
                n_p1 = issue;
                n_pa = r_idx[IW-1:0];
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_p1) begin
                    if (r_hit) begin
                        o_hl_we = !r_sel;
                        o_cl_we = r_sel;
                    end else if (ls_rdata == r_frame) begin
                        n_hit = 1'b1;
                    end
                end
                if (!issue && !r_p1) begin
                    if (r_hit) begin
                        if (r_sel) begin
                            n_clen = r_clen - 1'b1;
                        end else begin
                            n_hlen = r_hlen - 1'b1;
                        end
                    end
                    n_state = r_push ? S_PUSH : S_DONE;
                end
            end
            S_PUSH: begin
                o_ls_waddr = r_clen[IW-1:0];
                o_ls_wdata = r_frame;
                o_cl_we    = 1'b1;
                n_clen     = r_clen + 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_found  = r_found;
                    n_out_victim = r_victim;
                    n_out_count  = r_tev;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_hit       <= 1'b0;
            r_hlen      <= '0;
            r_clen      <= '0;
            r_tev       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_p1        <= n_p1;
            r_p2        <= n_p2;
            r_hit       <= n_hit;
            r_hlen      <= n_hlen;
            r_clen      <= n_clen;
            r_tev       <= n_tev;
            r_out_valid <= n_out_valid;
        end
        r_req        <= n_req;
        r_frame      <= n_frame;
        r_flag       <= n_flag;
        r_sel        <= n_sel;
        r_push       <= n_push;
        r_pa         <= n_pa;
        r_c2         <= n_c2;
        r_found      <= n_found;
        r_victim     <= n_victim;
        r_out_found  <= n_out_found;
        r_out_victim <= n_out_victim;
        r_out_count  <= n_out_count;
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_victim    = r_out_victim;
    assign o_count     = r_out_count;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("replacer still ready the cycle after taking a request");

    a_lists_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((SW'(r_hlen) + SW'(r_clen)) <= SW'(FRAME_SLOTS)))
        else $error("history and cache lists hold more entries than frames");

    // A moving frame is briefly on neither list while it waits to be pushed.
    a_evictable_listed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_PUSH) |-> (SW'(r_tev) <= (SW'(r_hlen) + SW'(r_clen))))
        else $error("evictable count exceeds the number of listed frames");
`endif

endmodule

// ----- design/lru_k_frame_replacer.sv -----
// Top level of the LRU-K frame replacer: ports, threshold register and memories.
//
// The replacer tracks up to FRAME_SLOTS buffer frames and takes one request at a
// time (record access, set evictable, remove, evict), returning one result for
// each. After reset a clearing pass writes the frame table, one entry per cycle,
// while s_axis_tready stays low. Any request that takes a frame out of a list
// walks that list through one read port and rewrites it one entry per cycle,
// then pushes the frame onto the cache list when it moves there. Evict first
// scans the history list and then the cache list, one entry per cycle through a
// two-step read of list and frame table, and then comes the walk that drops the
// victim. s_axis_tready is high only between requests; a finished result waits
// in the output register while the next request is taken. The user must write
// the threshold k through i_cfg_we and i_cfg_wdata only while the replacer is
// idle; the block itself has no such check. Values below 2 act as 2 and values
// above 16 act as 16.
module lru_k_frame_replacer
    import lkr_pkg::*;
#(
    parameter int FRAME_SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // threshold register write
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [5:0] frame, [6] evictable_flag, [7] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [5:0] victim_frame, [12:6] evictable_count,
                                        // [15:13] zero
    output logic [0:0]  m_axis_tuser    // [0] victim_found
);

    localparam int IW = $clog2(FRAME_SLOTS);

    logic [K_W-1:0]     r_k;
    logic [K_W-1:0]     k_eff;

    logic               ft_we;
    logic [IW-1:0]      ft_waddr;
    t_ftab_entry        ft_wdata;
    logic [IW-1:0]      ft_raddr;
    t_ftab_entry        ft_rdata;

    logic [IW-1:0]      ls_raddr;
    logic [IW-1:0]      ls_waddr;
    logic [FRAME_W-1:0] ls_wdata;
    logic               hl_we;
    logic               cl_we;
    logic [FRAME_W-1:0] hl_rdata;
    logic [FRAME_W-1:0] cl_rdata;

    logic               found;
    logic [FRAME_W-1:0] victim;
    logic [TEV_W-1:0]   count;

    // The raw value is kept as written; the clamp is applied on the way out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= K_RESET;
        end else if (i_cfg_we) begin
            r_k <= i_cfg_wdata;
        end
    end

    assign k_eff = (r_k < K_MIN) ? K_MIN : ((r_k > K_MAX) ? K_MAX : r_k);

    lkr_ctrl #(
        .FRAME_SLOTS (FRAME_SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_k         (k_eff),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_req       (t_req'(s_axis_tuser)),
        .i_frame     (s_axis_tdata[5:0]),
        .i_flag      (s_axis_tdata[6]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_found     (found),
        .o_victim    (victim),
        .o_count     (count),
        .o_ft_we     (ft_we),
        .o_ft_waddr  (ft_waddr),
        .o_ft_wdata  (ft_wdata),
        .o_ft_raddr  (ft_raddr),
        .i_ft_rdata  (ft_rdata),
        .o_ls_raddr  (ls_raddr),
        .o_ls_waddr  (ls_waddr),
        .o_ls_wdata  (ls_wdata),
        .o_hl_we     (hl_we),
        .o_cl_we     (cl_we),
        .i_hl_rdata  (hl_rdata),
        .i_cl_rdata  (cl_rdata)
    );

    // Per-frame table: access count, evictable mark and which list holds the frame.
    lkr_ram #(
        .DEPTH (FRAME_SLOTS),
        .WIDTH (FTAB_W)
    ) u_ftab (
        .i_clk   (i_clk),
        .i_we    (ft_we),
        .i_waddr (ft_waddr),
        .i_wdata (ft_wdata),
        .i_raddr (ft_raddr),
        .o_rdata (ft_rdata)
    );

    // History list, oldest first access at entry 0.
    lkr_ram #(
        .DEPTH (FRAME_SLOTS),
        .WIDTH (FRAME_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (hl_we),
        .i_waddr (ls_waddr),
        .i_wdata (ls_wdata),
        .i_raddr (ls_raddr),
        .o_rdata (hl_rdata)
    );

    // Cache list, least recently used at entry 0.
    lkr_ram #(
        .DEPTH (FRAME_SLOTS),
        .WIDTH (FRAME_W)
    ) u_cache (
        .i_clk   (i_clk),
        .i_we    (cl_we),
        .i_waddr (ls_waddr),
        .i_wdata (ls_wdata),
        .i_raddr (ls_raddr),
        .o_rdata (cl_rdata)
    );

    assign m_axis_tdata = {3'b000, count, victim};
    assign m_axis_tuser = found;

endmodule
